// ----- rtl/bffz_pkg.sv -----
// Shared constants, operation codes and types for the bitmap find-first-zero block.
package bffz_pkg;

  localparam int MAX_BITS   = 4096;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int OFS_W      = 6;
  localparam int WADDR_W    = 6;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BITS);

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_TOGGLE = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_FILL   = 3'd4;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic             use_start;
    logic [OFS_W-1:0] start_ofs;
    logic             use_lim;
    logic [OFS_W-1:0] lim_ofs;
  } scan_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [OFS_W-1:0] pos;
  } scan_res_t;

  function automatic logic [OFS_W-1:0] first_one(input word_t v);
    logic [OFS_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = OFS_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// ----- rtl/bffz_word_scan.sv -----
// Masks one bitmap word to the search window and locates its lowest zero flag.
module bffz_word_scan
  import bffz_pkg::*;
(
  input  word_t     word,
  input  scan_ctl_t ctl,
  output scan_res_t res
);

  word_t zeros;

  always_comb begin
    zeros = ~word;
    if (ctl.use_start) begin
      zeros = zeros & ({WORD_BITS{1'b1}} << ctl.start_ofs);
    end
    // partial last word: keep only flags below the item count
    if (ctl.use_lim) begin
      zeros = zeros & ~({WORD_BITS{1'b1}} << ctl.lim_ofs);
    end
    res.hit = |zeros;
    res.pos = first_one(zeros);
  end

endmodule

// ----- rtl/bitmap_find_first_zero_core.sv -----
// Bitmap flag store with read, write, toggle, fill and find-first-zero requests.
// Bit access, fill and refused requests: the word read is registered, then the result is registered.
// A search reads one 64-bit word per cycle, walking at most 64 words.
// One request in flight: input is ready again only when the result is registered.
// Reset: all flags read as zero at once (per-word valid bits), item count returns to 4096.
// Fill works by clearing the valid bits and latching the fill value.
module bitmap_find_first_zero_core
  import bffz_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // op[2:0], index[14:3], value[15]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // bit_res[0], accepted[1], found[2],
                                       // found_index[14:3], zero[15]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  word_t                mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] word_vld_r;
  logic                 fill_val_r;
  word_t                rd_data_r;
  logic                 rd_vld_r;

  logic [CNT_W-1:0]   cnt_r;
  logic [WADDR_W-1:0] last_w_r;

  logic               st_r, st_nxt;
  logic [2:0]         op_r;
  logic [IDX_W-1:0]   idx_r;
  logic               val_r;
  logic [WADDR_W-1:0] cur_w_r, cur_w_nxt;
  logic               first_r, first_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  logic               in_xfer;
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  word_t              word_cur;
  word_t              word_new;
  word_t              bmask;
  logic               in_rng;
  logic               out_free;
  logic               search_more;
  logic               done;
  logic               wr_en;
  logic               fill_en;
  logic               bit_res;
  logic               accepted;
  logic               found;
  logic [IDX_W-1:0]   found_index;
  logic [CNT_W-1:0]   cfg_sat;
  logic [CNT_W-1:0]   cfg_m1;
  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;

  assign in_tready  = (st_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_sat = (cfg_data > MAX_CNT) ? MAX_CNT : cfg_data;
  assign cfg_m1  = cfg_sat - CNT_W'(1);

  assign word_cur = rd_vld_r ? rd_data_r : {WORD_BITS{fill_val_r}};
  assign in_rng   = ({1'b0, idx_r} < cnt_r);
  assign bmask    = word_t'(1) << idx_r[OFS_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  assign scan_ctl.use_start = first_r;
  assign scan_ctl.start_ofs = idx_r[OFS_W-1:0];
  assign scan_ctl.use_lim   = (cur_w_r == last_w_r) && (cnt_r[OFS_W-1:0] != '0);
  assign scan_ctl.lim_ofs   = cnt_r[OFS_W-1:0];

  bffz_word_scan u_scan (
    .word (word_cur),
    .ctl  (scan_ctl),
    .res  (scan_res)
  );

  // walk on to the next word while the search window still has words left
  assign search_more = (st_r == ST_EXEC) && (op_r == OP_FIND) && in_rng &&
                       !scan_res.hit && (cur_w_r != last_w_r);
  assign done        = (st_r == ST_EXEC) && !search_more && out_free;
  assign rd_en       = in_xfer || search_more;
  assign rd_addr     = in_xfer ? in_tdata[14:9] : cur_w_r + WADDR_W'(1);

  always_comb begin
    word_new    = word_cur;
    bit_res     = 1'b0;
    accepted    = 1'b0;
    found       = 1'b0;
    found_index = '0;
    wr_en       = 1'b0;
    fill_en     = 1'b0;
    case (op_r)
      OP_READ, OP_WRITE, OP_TOGGLE: begin
        if (op_r == OP_WRITE) begin
          word_new = val_r ? (word_cur | bmask) : (word_cur & ~bmask);
        end else if (op_r == OP_TOGGLE) begin
          word_new = word_cur ^ bmask;
        end
        if (in_rng) begin
          bit_res  = word_new[idx_r[OFS_W-1:0]];
          accepted = 1'b1;
          wr_en    = (op_r != OP_READ);
        end
      end
      OP_FIND: begin
        if (in_rng) begin
          accepted = 1'b1;
          if (scan_res.hit) begin
            found       = 1'b1;
            found_index = {cur_w_r, scan_res.pos};
          end
        end
      end
      OP_FILL: begin
        accepted = 1'b1;
        fill_en  = 1'b1;
      end
      default: begin
        accepted = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    cur_w_nxt     = cur_w_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      st_nxt    = ST_EXEC;
      cur_w_nxt = in_tdata[14:9];
      first_nxt = 1'b1;
    end else if (search_more) begin
      cur_w_nxt = cur_w_r + WADDR_W'(1);
      first_nxt = 1'b0;
    end else if (done) begin
      st_nxt        = ST_IDLE;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, found_index, found, accepted, bit_res};
    end
  end

  // memory: one synchronous read port, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (done && wr_en) begin
      mem[idx_r[IDX_W-1:OFS_W]] <= word_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= '0;
      fill_val_r <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= word_vld_r[rd_addr];
      end
      if (done && fill_en) begin
        word_vld_r <= '0;
        fill_val_r <= val_r;
      end else if (done && wr_en) begin
        word_vld_r[idx_r[IDX_W-1:OFS_W]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= MAX_CNT;
      last_w_r    <= WADDR_W'(WORD_COUNT - 1);
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cnt_r    <= cfg_sat;
        last_w_r <= cfg_m1[IDX_W-1:OFS_W];
      end
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_tdata[2:0];
      idx_r <= in_tdata[14:3];
      val_r <= in_tdata[15];
    end
    cur_w_r    <= cur_w_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/bffz_chk.sv -----
// Port-level checker for the bitmap find-first-zero block, bound to the top level.
module bffz_chk
  import bffz_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight: no transfer right after a transfer
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in flight");

  a_found_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1])
    else $error("found without accepted");

  a_bit_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1] && !out_tdata[2])
    else $error("bit result on refused request or search");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> (out_tdata[14:3] == '0) && !out_tdata[15])
    else $error("found_index or padding nonzero without a hit");

endmodule

bind bitmap_find_first_zero_core bffz_chk u_bffz_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the bitmap find-first-zero core: directed table, then random phases.
module testbench;
  import bffz_pkg::*;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_LEN   = 80;
  localparam int PHASE_ITEMS  = 162;
  localparam int PHASE_TOTAL  = 10;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] index;
    logic             value;
  } flag_req_t;

  typedef struct packed {
    logic             bit_res;
    logic             accepted;
    logic             found;
    logic [IDX_W-1:0] found_index;
  } flag_res_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] cnt;
    flag_req_t        req;
    bit               typed;
    flag_res_t        res;
  } plan_row_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data   = '0;

  // Shadow copy of the flag store and the item count register
  word_t            shadow_words [WORD_COUNT];
  logic [CNT_W-1:0] shadow_count;

  flag_res_t        pending_results [$];
  plan_row_t        plan [$];
  int               mismatch_count = 0;
  int               results_seen   = 0;
  int               burst_left     = 0;
  bit               steady_sender  = 1'b0;
  int unsigned      cyc            = 0;
  int               rx_mode        = 0;
  logic [7:0]       rx_mask        = 8'hff;

  bitmap_find_first_zero_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int live_items();
    return (shadow_count > MAX_CNT) ? MAX_BITS : int'(shadow_count);
  endfunction

  // Apply one request to the shadow store and work out its result
  task automatic predict_bitmap(input flag_req_t r, output flag_res_t res);
    int lim;
    int w;
    int p;
    lim = live_items();
    w   = int'(r.index) / WORD_BITS;
    res = '0;
    case (r.op)
      OP_READ, OP_WRITE, OP_TOGGLE: begin
        if (int'(r.index) < lim) begin
          if (r.op == OP_WRITE) begin
            shadow_words[w][r.index[OFS_W-1:0]] = r.value;
          end else if (r.op == OP_TOGGLE) begin
            shadow_words[w][r.index[OFS_W-1:0]] = ~shadow_words[w][r.index[OFS_W-1:0]];
          end
          res.bit_res  = shadow_words[w][r.index[OFS_W-1:0]];
          res.accepted = 1'b1;
        end
      end
      OP_FIND: begin
        if (int'(r.index) < lim) begin
          res.accepted = 1'b1;
          for (p = int'(r.index); p < lim && !res.found; p++) begin
            if (!shadow_words[p / WORD_BITS][p % WORD_BITS]) begin
              res.found       = 1'b1;
              res.found_index = IDX_W'(p);
            end
          end
        end
      end
      OP_FILL: begin
        for (int i = 0; i < WORD_COUNT; i++) begin
          shadow_words[i] = {WORD_BITS{r.value}};
        end
        res.accepted = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  // Offer one request, wait for its transfer, then queue its result
  task automatic issue_req(input flag_req_t r, input bit typed, input flag_res_t typed_res);
    flag_res_t pred;
    int        gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {r.value, r.index, r.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_bitmap(r, pred);
    pending_results.push_back(typed ? typed_res : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let the block go idle, then write the item count
  task automatic set_item_count(input logic [CNT_W-1:0] cnt);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    shadow_count  = cnt;
  endtask

  function automatic flag_req_t mk_req(input logic [2:0] op, input int idx, input logic v);
    flag_req_t r;
    r.op    = op;
    r.index = IDX_W'(idx);
    r.value = v;
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic [2:0] op, input int idx, input logic v);
    plan_row_t row;
    row.kind  = ROW_REQ;
    row.cnt   = '0;
    row.req   = mk_req(op, idx, v);
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic plan_row_t chk_row(input logic [2:0] op, input int idx, input logic v,
                                        input logic b, input logic a, input logic f,
                                        input int fi);
    plan_row_t row;
    row       = req_row(op, idx, v);
    row.typed = 1'b1;
    row.res   = {b, a, f, IDX_W'(fi)};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input int cnt);
    plan_row_t row;
    row      = req_row(OP_READ, 0, 1'b0);
    row.kind = ROW_CFG;
    row.cnt  = CNT_W'(cnt);
    return row;
  endfunction

  function automatic flag_req_t random_req();
    flag_req_t r;
    int        lim;
    int        pick;
    int        idx;
    lim  = live_items();
    pick = $urandom_range(0, 99);
    if (pick < 25)      r.op = OP_READ;
    else if (pick < 55) r.op = OP_WRITE;
    else if (pick < 70) r.op = OP_TOGGLE;
    else if (pick < 92) r.op = OP_FIND;
    else if (pick < 96) r.op = OP_FILL;
    else                r.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
    // favor fills with ones so searches must walk over full words
    if (r.op == OP_FILL) r.value = ($urandom_range(0, 9) < 7);
    else                 r.value = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: idx = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 4095);
      5:             idx = lim - 2 + $urandom_range(0, 3);
      6:             idx = $urandom_range(0, WORD_COUNT - 1) * WORD_BITS
                           + ($urandom_range(0, 1) ? 0 : WORD_BITS - 1);
      9:             idx = $urandom_range(0, 1) ? 0 : MAX_BITS - 1;
      default:       idx = $urandom_range(0, MAX_BITS - 1);
    endcase
    if (idx < 0) idx = 0;
    if (idx > MAX_BITS - 1) idx = MAX_BITS - 1;
    r.index = IDX_W'(idx);
    return r;
  endfunction

  // Receiver stalls: mode and mask are redrawn whenever the low byte of the cycle counter is zero
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      if (cyc[7:0] == 8'd0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mask <= 8'($urandom_range(0, 255)) | 8'h01;
      end
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= rx_mask[cyc[2:0]];
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    flag_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending: tdata 0x%04h",
                                  results_seen, out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.bit_res)
          report_mismatch($sformatf("result %0d bit_res got %0b want %0b",
                                    results_seen, out_tdata[0], want.bit_res));
        if (out_tdata[1] !== want.accepted)
          report_mismatch($sformatf("result %0d accepted got %0b want %0b",
                                    results_seen, out_tdata[1], want.accepted));
        if (out_tdata[2] !== want.found)
          report_mismatch($sformatf("result %0d found got %0b want %0b",
                                    results_seen, out_tdata[2], want.found));
        if (out_tdata[14:3] !== want.found_index)
          report_mismatch($sformatf("result %0d found_index got %0d want %0d",
                                    results_seen, out_tdata[14:3], want.found_index));
        if (out_tdata[15] !== 1'b0)
          report_mismatch($sformatf("result %0d padding bit set", results_seen));
      end
    end
  end

  initial begin
    int phase_counts [PHASE_TOTAL];
    for (int i = 0; i < WORD_COUNT; i++) shadow_words[i] = '0;
    shadow_count = MAX_CNT;
    phase_counts = '{4096, 1, 64, 65, 0, 8191, 127, 4095, 2000, 4096};
    phase_counts[8] = $urandom_range(1, MAX_BITS);

    // store empty after reset, count at its reset value
    plan.push_back(chk_row(OP_READ,   0,    1'b0, 1'b0, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   0,    1'b0, 1'b0, 1'b1, 1'b1, 0));
    plan.push_back(chk_row(OP_WRITE,  4095, 1'b1, 1'b1, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_TOGGLE, 4095, 1'b0, 1'b0, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_TOGGLE, 0,    1'b1, 1'b1, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   0,    1'b0, 1'b0, 1'b1, 1'b1, 1));
    // full store: search finds nothing
    plan.push_back(chk_row(OP_FILL,   0,    1'b1, 1'b0, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   0,    1'b0, 1'b0, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_WRITE,  100,  1'b0, 1'b0, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   5,    1'b1, 1'b0, 1'b1, 1'b1, 100));
    plan.push_back(chk_row(OP_WRITE,  4095, 1'b0, 1'b0, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   101,  1'b0, 1'b0, 1'b1, 1'b1, 4095));
    plan.push_back(req_row(OP_TOGGLE, 64,   1'b0));
    plan.push_back(chk_row(OP_FIND,   64,   1'b0, 1'b0, 1'b1, 1'b1, 64));
    plan.push_back(chk_row(OP_SPARE5, 4095, 1'b1, 1'b0, 1'b0, 1'b0, 0));
    plan.push_back(chk_row(OP_SPARE6, 2048, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    plan.push_back(chk_row(OP_SPARE7, 0,    1'b1, 1'b0, 1'b0, 1'b0, 0));
    // single valid flag
    plan.push_back(cfg_row(1));
    plan.push_back(chk_row(OP_READ,   0,    1'b0, 1'b1, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_READ,   1,    1'b0, 1'b0, 1'b0, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   1,    1'b0, 1'b0, 1'b0, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   0,    1'b0, 1'b0, 1'b1, 1'b0, 0));
    // no valid flags: everything refused but fill
    plan.push_back(cfg_row(0));
    plan.push_back(chk_row(OP_WRITE,  0,    1'b1, 1'b0, 1'b0, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   0,    1'b0, 1'b0, 1'b0, 1'b0, 0));
    plan.push_back(chk_row(OP_FILL,   0,    1'b0, 1'b0, 1'b1, 1'b0, 0));
    // count above the store size saturates
    plan.push_back(cfg_row(8191));
    plan.push_back(chk_row(OP_WRITE,  4095, 1'b1, 1'b1, 1'b1, 1'b0, 0));
    plan.push_back(chk_row(OP_FIND,   4000, 1'b0, 1'b0, 1'b1, 1'b1, 4000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_item_count(plan[i].cnt);
      else issue_req(plan[i].req, plan[i].typed, plan[i].res);
    end

    for (int ph = 0; ph < PHASE_TOTAL; ph++) begin
      set_item_count(CNT_W'(phase_counts[ph]));
      steady_sender = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) issue_req(random_req(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
